### hw/rtl/bctm_pkg.sv
`default_nettype none
package bctm_pkg;
   localparam int SUPER_ROWS = 2;
   localparam int SUPER_COLS = 2;
   localparam int QW = 17;
   localparam int MW = 4;
   localparam int GW = 9;
   localparam int AW = 3;
   localparam int DW = 24;

   typedef enum logic [AW-1:0] {
      REG_ROW_OFFSET = 3'd0,
      REG_COL_OFFSET = 3'd1,
      REG_GRID_ROWS = 3'd2,
      REG_GRID_COLS = 3'd3,
      REG_LOCAL_ROWS = 3'd4,
      REG_TOTAL_ROWS = 3'd5,
      REG_TOTAL_COLS = 3'd6,
      REG_TILE_BYTES = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic valid;
      logic [QW-1:0] dr;
      logic [QW-1:0] dc;
      logic [QW-1:0] qr;
      logic [QW-1:0] qc;
      logic [GW-1:0] rr;
      logic [GW-1:0] rc;
      logic [MW-1:0] mr;
      logic [MW-1:0] nc;
      logic row_last;
      logic col_last;
   } lane_type;
endpackage
`default_nettype wire

### hw/rtl/bctm_cell.sv
`default_nettype none
module bctm_cell (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic en,
   input  wire logic [bctm_pkg::GW-1:0] gr,
   input  wire logic [bctm_pkg::GW-1:0] gc,
   input  wire bctm_pkg::lane_type lane_in,
   output bctm_pkg::lane_type lane_out
);
   bctm_pkg::lane_type lane_ff, lane_in_next;
   logic [bctm_pkg::GW:0] tr, tc;
   logic ger, gec;

   always_comb begin
      tr = {lane_in.rr, lane_in.dr[bctm_pkg::QW-1]};
      tc = {lane_in.rc, lane_in.dc[bctm_pkg::QW-1]};
      ger = tr >= {1'b0, gr};
      gec = tc >= {1'b0, gc};
      lane_in_next = lane_in;
      lane_in_next.dr = {lane_in.dr[bctm_pkg::QW-2:0], 1'b0};
      lane_in_next.dc = {lane_in.dc[bctm_pkg::QW-2:0], 1'b0};
      lane_in_next.qr = {lane_in.qr[bctm_pkg::QW-2:0], ger};
      lane_in_next.qc = {lane_in.qc[bctm_pkg::QW-2:0], gec};
      lane_in_next.rr = ger ? bctm_pkg::GW'(tr - {1'b0, gr}) : bctm_pkg::GW'(tr);
      lane_in_next.rc = gec ? bctm_pkg::GW'(tc - {1'b0, gc}) : bctm_pkg::GW'(tc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end else if (en) begin
         lane_ff.valid <= lane_in_next.valid;
      end
      if (en) begin
         lane_ff.dr <= lane_in_next.dr;
         lane_ff.dc <= lane_in_next.dc;
         lane_ff.qr <= lane_in_next.qr;
         lane_ff.qc <= lane_in_next.qc;
         lane_ff.rr <= lane_in_next.rr;
         lane_ff.rc <= lane_in_next.rc;
         lane_ff.mr <= lane_in_next.mr;
         lane_ff.nc <= lane_in_next.nc;
         lane_ff.row_last <= lane_in_next.row_last;
         lane_ff.col_last <= lane_in_next.col_last;
      end
   end

   assign lane_out = lane_ff;

`ifndef NO_ASSERTIONS
   a_rem_row: assert property (@(posedge clock) disable iff (reset)
      (en && lane_in.valid && lane_in.rr < gr) |=> (lane_ff.rr < $past(gr)))
      else $error("row remainder not below divisor");
   a_rem_col: assert property (@(posedge clock) disable iff (reset)
      (en && lane_in.valid && lane_in.rc < gc) |=> (lane_ff.rc < $past(gc)))
      else $error("column remainder not below divisor");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(lane_ff.valid))
      else $error("cell moved while stalled");
`endif
endmodule
`default_nettype wire

### hw/rtl/bctm_back.sv
`default_nettype none
module bctm_back (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic en,
   input  wire bctm_pkg::lane_type lane_in,
   input  wire logic [bctm_pkg::GW-1:0] gc,
   input  wire logic [15:0] local_rows,
   input  wire logic [15:0] total_rows,
   input  wire logic [15:0] total_cols,
   input  wire logic [23:0] tile_bytes,
   output logic out_valid,
   output logic [15:0] owner_rank,
   output logic [31:0] local_index,
   output logic [47:0] byte_offset
);
   logic [4:0] rows_here;
   logic [8:0] blk;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [31:0] p1_ff, p2_ff, idx_ff, idx3_ff;
   logic [8:0] p3_ff;
   logic [bctm_pkg::MW-1:0] mr_ff;
   logic [15:0] rank1_ff, rank2_ff, rank3_ff;
   logic [47:0] bytes_ff;
   logic [32:0] p1_in;
   logic [33:0] p2_in;
   logic [17:0] rank_in;

   always_comb begin
      rows_here = lane_in.row_last ?
         5'(total_rows % 16'(bctm_pkg::SUPER_ROWS)) : 5'(bctm_pkg::SUPER_ROWS);
      blk = lane_in.col_last ?
         9'(5'(total_cols % 16'(bctm_pkg::SUPER_COLS)) * 5'(bctm_pkg::SUPER_ROWS)) :
         9'(bctm_pkg::SUPER_COLS * bctm_pkg::SUPER_ROWS);
      p1_in = 33'(local_rows) * 33'(lane_in.qc);
      p2_in = 34'(blk) * 34'(lane_in.qr);
      rank_in = 18'(lane_in.rr) * 18'(gc) + 18'(lane_in.rc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= lane_in.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
      if (en) begin
         p1_ff <= p1_in[31:0];
         p2_ff <= p2_in[31:0];
         p3_ff <= 9'(lane_in.nc) * 9'(rows_here);
         mr_ff <= lane_in.mr;
         rank1_ff <= rank_in[15:0];
         idx_ff <= 32'(p1_ff * 32'(bctm_pkg::SUPER_COLS)) + p2_ff + 32'(p3_ff) + 32'(mr_ff);
         rank2_ff <= rank1_ff;
         bytes_ff <= 48'(56'(idx_ff) * 56'(tile_bytes));
         idx3_ff <= idx_ff;
         rank3_ff <= rank2_ff;
      end
   end

   assign out_valid = s3_valid_ff;
   assign owner_rank = rank3_ff;
   assign local_index = idx3_ff;
   assign byte_offset = bytes_ff;

`ifndef NO_ASSERTIONS
   a_flow: assert property (@(posedge clock) disable iff (reset)
      en |=> (s3_valid_ff == $past(s2_valid_ff)))
      else $error("output stage skipped a beat");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(idx3_ff) && $stable(bytes_ff))
      else $error("result changed while stalled");
   a_small: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (mr_ff < 4'(bctm_pkg::SUPER_ROWS)))
      else $error("row phase out of range");
`endif
endmodule
`default_nettype wire

### hw/rtl/block_cyclic_tile_mapper.sv
// Channel | Dir | Fields (low bit up)
// req     | in  | tdata: tile_row[15:0], tile_col[31:16]
// rsp     | out | tdata: owner_rank[15:0], local_index[47:16], byte_offset[95:48]
// csr     | in  | write enable, 3-bit register index, 24-bit data
// One beat per cycle while rsp is not stalled; stages: front, 17 divider cells, 3 back stages.
// The divider chain gives one quotient bit per cell for both grid divisions.
// Reset is synchronous and clears valid bits and configuration registers to defaults.
// A stalled rsp freezes the whole pipe; req_tready drops only then.
`default_nettype none
module block_cyclic_tile_mapper (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic req_tready,
   input  wire logic [31:0] req_tdata,   // tile_row, tile_col
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   output logic [95:0] rsp_tdata,        // owner_rank, local_index, byte_offset
   input  wire logic csr_we,
   input  wire logic [bctm_pkg::AW-1:0] csr_addr,
   input  wire logic [bctm_pkg::DW-1:0] csr_wdata
);
   localparam int QW = bctm_pkg::QW;
   logic [15:0] row_off_ff, col_off_ff, local_rows_ff, total_rows_ff, total_cols_ff;
   logic [8:0] grid_rows_ff, grid_cols_ff, gr, gc;
   logic [23:0] tile_bytes_ff;
   logic en;
   logic [QW-1:0] m, n;
   bctm_pkg::lane_type front_in, front_ff;
   bctm_pkg::lane_type chain [QW+1];
   logic [15:0] owner_rank;
   logic [31:0] local_index;
   logic [47:0] byte_offset;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_off_ff <= '0;
         col_off_ff <= '0;
         grid_rows_ff <= 9'd1;
         grid_cols_ff <= 9'd1;
         local_rows_ff <= '0;
         total_rows_ff <= 16'd1;
         total_cols_ff <= 16'd1;
         tile_bytes_ff <= 24'd1;
      end else if (csr_we) begin
         case (bctm_pkg::reg_index_type'(csr_addr))
            bctm_pkg::REG_ROW_OFFSET: row_off_ff <= csr_wdata[15:0];
            bctm_pkg::REG_COL_OFFSET: col_off_ff <= csr_wdata[15:0];
            bctm_pkg::REG_GRID_ROWS: grid_rows_ff <= csr_wdata[8:0];
            bctm_pkg::REG_GRID_COLS: grid_cols_ff <= csr_wdata[8:0];
            bctm_pkg::REG_LOCAL_ROWS: local_rows_ff <= csr_wdata[15:0];
            bctm_pkg::REG_TOTAL_ROWS: total_rows_ff <= csr_wdata[15:0];
            bctm_pkg::REG_TOTAL_COLS: total_cols_ff <= csr_wdata[15:0];
            bctm_pkg::REG_TILE_BYTES: tile_bytes_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign gr = (grid_rows_ff == '0) ? 9'd1 : grid_rows_ff;
   assign gc = (grid_cols_ff == '0) ? 9'd1 : grid_cols_ff;
   assign en = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   always_comb begin
      m = {1'b0, req_tdata[15:0]} + {1'b0, row_off_ff};
      n = {1'b0, req_tdata[31:16]} + {1'b0, col_off_ff};
      front_in.valid = req_tvalid;
      front_in.dr = m / QW'(bctm_pkg::SUPER_ROWS);
      front_in.dc = n / QW'(bctm_pkg::SUPER_COLS);
      front_in.qr = '0;
      front_in.qc = '0;
      front_in.rr = '0;
      front_in.rc = '0;
      front_in.mr = bctm_pkg::MW'(m % QW'(bctm_pkg::SUPER_ROWS));
      front_in.nc = bctm_pkg::MW'(n % QW'(bctm_pkg::SUPER_COLS));
      front_in.row_last = m >= QW'(({1'b0, total_rows_ff} / QW'(bctm_pkg::SUPER_ROWS))
                                   * QW'(bctm_pkg::SUPER_ROWS));
      front_in.col_last = n >= QW'(({1'b0, total_cols_ff} / QW'(bctm_pkg::SUPER_COLS))
                                   * QW'(bctm_pkg::SUPER_COLS));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff.valid <= 1'b0;
      end else if (en) begin
         front_ff.valid <= front_in.valid;
      end
      if (en) begin
         front_ff.dr <= front_in.dr;
         front_ff.dc <= front_in.dc;
         front_ff.qr <= front_in.qr;
         front_ff.qc <= front_in.qc;
         front_ff.rr <= front_in.rr;
         front_ff.rc <= front_in.rc;
         front_ff.mr <= front_in.mr;
         front_ff.nc <= front_in.nc;
         front_ff.row_last <= front_in.row_last;
         front_ff.col_last <= front_in.col_last;
      end
   end

   assign chain[0] = front_ff;

   for (genvar i = 0; i < QW; i++) begin : g_cell
      bctm_cell u_cell (
         .clock(clock),
         .reset(reset),
         .en(en),
         .gr(gr),
         .gc(gc),
         .lane_in(chain[i]),
         .lane_out(chain[i+1])
      );
   end

   bctm_back u_back (
      .clock(clock),
      .reset(reset),
      .en(en),
      .lane_in(chain[QW]),
      .gc(gc),
      .local_rows(local_rows_ff),
      .total_rows(total_rows_ff),
      .total_cols(total_cols_ff),
      .tile_bytes(tile_bytes_ff),
      .out_valid(rsp_tvalid),
      .owner_rank(owner_rank),
      .local_index(local_index),
      .byte_offset(byte_offset)
   );

   assign rsp_tdata = {byte_offset, local_index, owner_rank};

`ifndef NO_ASSERTIONS
   a_ready: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input taken while output stalled");
   a_front: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> front_ff.valid)
      else $error("accepted beat lost at front");
   a_grid: assert property (@(posedge clock) disable iff (reset)
      (gr != 9'd0) && (gc != 9'd0))
      else $error("zero grid divisor");
`endif
endmodule
`default_nettype wire

### tb/tb_block_cyclic_tile_mapper.sv
`timescale 1ns / 1ps
module tb_block_cyclic_tile_mapper;

   typedef struct packed {
      logic [47:0] byte_offset;
      logic [31:0] local_index;
      logic [15:0] owner_rank;
   } tile_loc_type;

   typedef struct {
      logic [15:0]  row;
      logic [15:0]  col;
      bit           known;
      tile_loc_type loc;
   } coord_row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [31:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [95:0] rsp_tdata;
   logic csr_we = 0;
   logic [bctm_pkg::AW-1:0] csr_addr = '0;
   logic [bctm_pkg::DW-1:0] csr_wdata = '0;

   logic [15:0] row_off, col_off, loc_rows, tot_rows, tot_cols;
   logic [8:0]  g_rows, g_cols;
   logic [23:0] t_bytes;

   tile_loc_type pending_locs[$];
   int errors = 0;
   bit sender_done = 0;

   block_cyclic_tile_mapper i_dut (.*);

   initial forever #5 clock = ~clock;

   initial begin
      #50_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic tile_loc_type map_tile(logic [15:0] tr, logic [15:0] tc);
      logic [31:0] gr, gc, m, n, sr, sc, idx, blk, rows_here;
      logic [63:0] prod;
      tile_loc_type r;
      gr = (g_rows == 0) ? 1 : g_rows;
      gc = (g_cols == 0) ? 1 : g_cols;
      m = tr + row_off;
      n = tc + col_off;
      sr = m / bctm_pkg::SUPER_ROWS;
      sc = n / bctm_pkg::SUPER_COLS;
      r.owner_rank = 16'((sr % gr) * gc + (sc % gc));
      idx = loc_rows * bctm_pkg::SUPER_COLS * (sc / gc);
      if (n >= (tot_cols / bctm_pkg::SUPER_COLS) * bctm_pkg::SUPER_COLS)
         blk = (tot_cols % bctm_pkg::SUPER_COLS) * bctm_pkg::SUPER_ROWS;
      else
         blk = bctm_pkg::SUPER_COLS * bctm_pkg::SUPER_ROWS;
      idx += blk * (sr / gr);
      if (m >= (tot_rows / bctm_pkg::SUPER_ROWS) * bctm_pkg::SUPER_ROWS)
         rows_here = tot_rows % bctm_pkg::SUPER_ROWS;
      else
         rows_here = bctm_pkg::SUPER_ROWS;
      idx += (n % bctm_pkg::SUPER_COLS) * rows_here;
      idx += m % bctm_pkg::SUPER_ROWS;
      r.local_index = idx;
      prod = 64'(idx) * 64'(t_bytes);
      r.byte_offset = prod[47:0];
      return r;
   endfunction

   task automatic write_reg(bctm_pkg::reg_index_type idx, logic [bctm_pkg::DW-1:0] val);
      @(negedge clock);
      csr_we <= 1;
      csr_addr <= idx;
      csr_wdata <= val;
      case (idx)
         bctm_pkg::REG_ROW_OFFSET: row_off = val[15:0];
         bctm_pkg::REG_COL_OFFSET: col_off = val[15:0];
         bctm_pkg::REG_GRID_ROWS:  g_rows = val[8:0];
         bctm_pkg::REG_GRID_COLS:  g_cols = val[8:0];
         bctm_pkg::REG_LOCAL_ROWS: loc_rows = val[15:0];
         bctm_pkg::REG_TOTAL_ROWS: tot_rows = val[15:0];
         bctm_pkg::REG_TOTAL_COLS: tot_cols = val[15:0];
         bctm_pkg::REG_TILE_BYTES: t_bytes = val;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 0;
   endtask

   task automatic drain;
      req_tvalid <= 0;
      while (pending_locs.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   function automatic int gap_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
   endfunction

   task automatic send_coord(logic [15:0] tr, logic [15:0] tc, bit known, tile_loc_type loc,
                             bit bursty);
      int g;
      g = bursty ? 0 : gap_len();
      if (g != 0) begin
         req_tvalid <= 0;
         repeat (g) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {tc, tr};
      pending_locs.push_back(known ? loc : map_tile(tr, tc));
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic random_config(int mode);
      write_reg(bctm_pkg::REG_ROW_OFFSET,
                (mode == 0) ? 24'hFFFF : bctm_pkg::DW'($urandom_range(0, 65535)));
      write_reg(bctm_pkg::REG_COL_OFFSET,
                (mode == 0) ? 24'hFFFF : bctm_pkg::DW'($urandom_range(0, 65535)));
      write_reg(bctm_pkg::REG_GRID_ROWS, (mode == 0) ? 24'h1FF :
                ((mode == 1) ? 24'd0 : bctm_pkg::DW'($urandom_range(1, 256))));
      write_reg(bctm_pkg::REG_GRID_COLS, (mode == 0) ? 24'h1FF :
                ((mode == 1) ? 24'd0 : bctm_pkg::DW'($urandom_range(1, 256))));
      write_reg(bctm_pkg::REG_LOCAL_ROWS,
                (mode == 0) ? 24'hFFFF : bctm_pkg::DW'($urandom_range(0, 65535)));
      write_reg(bctm_pkg::REG_TOTAL_ROWS,
                (mode == 0) ? 24'hFFFF : bctm_pkg::DW'($urandom_range(0, 65535)));
      write_reg(bctm_pkg::REG_TOTAL_COLS,
                (mode == 0) ? 24'hFFFF : bctm_pkg::DW'($urandom_range(0, 65535)));
      write_reg(bctm_pkg::REG_TILE_BYTES,
                (mode == 0) ? 24'hFFFFFF : bctm_pkg::DW'($urandom_range(0, 24'hFFFFFF)));
   endtask

   // receiver: random stalls, check each beat
   always @(negedge clock) begin
      if (reset) rsp_tready <= 0;
      else if (sender_done && pending_locs.size() == 0) rsp_tready <= 1;
      else rsp_tready <= ($urandom_range(0, 9) < 7);
   end

   always @(posedge clock) begin
      tile_loc_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_locs.size() == 0) begin
            $display("%0t unexpected beat %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = pending_locs.pop_front();
            if (got.owner_rank !== want.owner_rank) begin
               $display("%0t owner_rank exp %h got %h", $time, want.owner_rank, got.owner_rank);
               errors++;
            end
            if (got.local_index !== want.local_index) begin
               $display("%0t local_index exp %h got %h", $time, want.local_index,
                        got.local_index);
               errors++;
            end
            if (got.byte_offset !== want.byte_offset) begin
               $display("%0t byte_offset exp %h got %h", $time, want.byte_offset,
                        got.byte_offset);
               errors++;
            end
         end
      end
   end

   initial begin
      coord_row_type dir_rows[$];
      int k, limit;
      row_off = 0; col_off = 0; g_rows = 1; g_cols = 1;
      loc_rows = 0; tot_rows = 1; tot_cols = 1; t_bytes = 1;

      // after reset: rank 0; index from total 1x1 (last-row/col corrections)
      dir_rows.push_back('{16'd0, 16'd0, 1, '{48'd0, 32'd0, 16'd0}});
      dir_rows.push_back('{16'd1, 16'd0, 1, '{48'd1, 32'd1, 16'd0}});
      dir_rows.push_back('{16'd0, 16'd1, 1, '{48'd1, 32'd1, 16'd0}});
      dir_rows.push_back('{16'hFFFF, 16'hFFFF, 0, '0});
      dir_rows.push_back('{16'hFFFF, 16'd0, 0, '0});
      dir_rows.push_back('{16'd0, 16'hFFFF, 0, '0});
      dir_rows.push_back('{16'h5555, 16'hAAAA, 0, '0});
      dir_rows.push_back('{16'hAAAA, 16'h5555, 0, '0});

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      foreach (dir_rows[i]) send_coord(dir_rows[i].row, dir_rows[i].col,
                                       dir_rows[i].known, dir_rows[i].loc, 0);
      drain();
      random_config(0);
      foreach (dir_rows[i]) if (i >= 3) send_coord(dir_rows[i].row, dir_rows[i].col, 0, '0, 0);
      drain();
      random_config(1);
      for (k = 0; k < 8; k++) send_coord(16'($urandom), 16'($urandom), 0, '0, 0);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         random_config(2);
         limit = 100;
         for (k = 0; k < limit; k++) begin
            if ($urandom_range(0, 1))
               send_coord(16'($urandom_range(0, 64)), 16'($urandom_range(0, 64)), 0, '0,
                          ph == 3);
            else
               send_coord(16'($urandom), 16'($urandom), 0, '0, ph == 3);
            if (k == 50) drain();
         end
         drain();
      end

      sender_done = 1;
      drain();
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
